/* rtl/pcl_pkg.sv */
// pcl_pkg: shared types, constants and arithmetic helpers for the phase current commutator
`default_nettype none

package pcl_pkg;

  localparam int unsigned TableDepth   = 1024;
  localparam int unsigned TableLog2    = $clog2(TableDepth);
  localparam int unsigned TableSlots   = 2 * TableDepth;
  localparam int unsigned SlotW        = $clog2(TableSlots);
  localparam int unsigned IdxW         = 10;
  localparam int unsigned PosW         = 32;
  localparam int unsigned CurW         = 16;
  localparam int unsigned EntryW       = 2 * CurW;
  localparam int unsigned OutW         = 9;
  localparam int unsigned WordW        = 25;
  localparam int unsigned ScaleW       = 9;
  localparam int unsigned Log2W        = 4;
  localparam int unsigned MaxMicroLog2 = 8;
  localparam int unsigned ScaleUnity   = 256;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 10;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_LOADED   = 2'd1,
    ST_LOAD_RUNNING = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALE      = 3'd0,
    REG_TABLE_LOG2 = 3'd1,
    REG_MICRO_LOG2 = 3'd2,
    REG_INVERT     = 3'd3,
    REG_OFFSET     = 3'd4
  } reg_e;

  // request to the table memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SlotW-1:0]  addr;
    logic [EntryW-1:0] wdata;
  } pcl_ram_req_t;

  // result fields travelling alongside the table read
  typedef struct packed {
    logic            wr;
    logic            rd;
    logic [IdxW-1:0] idx;
    logic            dir;
    status_e         status;
  } pcl_meta_t;

  function automatic logic [Log2W-1:0] tab_log2(input logic [Log2W-1:0] raw);
    return (raw > Log2W'(TableLog2)) ? Log2W'(TableLog2) : raw;
  endfunction

  function automatic logic [IdxW-1:0] phase_index(
    input logic [IdxW-1:0]  pos_lo,
    input logic [IdxW-1:0]  offset,
    input logic             invert,
    input logic [Log2W-1:0] micro_log2,
    input logic [Log2W-1:0] tl
  );
    logic [Log2W-1:0] ml;
    logic [Log2W-1:0] el;
    logic [IdxW-1:0]  mask;
    logic [IdxW-1:0]  off;
    logic [IdxW-1:0]  phase;
    ml    = (micro_log2 > Log2W'(MaxMicroLog2)) ? Log2W'(MaxMicroLog2) : micro_log2;
    el    = ml + Log2W'(2);
    mask  = ~({IdxW{1'b1}} << el);
    off   = offset & mask;
    phase = (invert ? (off - pos_lo) : (off + pos_lo)) & mask;
    return (tl >= el) ? (phase << (tl - el)) : (phase >> (el - tl));
  endfunction

  // product shifted right by 8 (floor) and cut to 9 bits
  function automatic logic [OutW-1:0] scale_9(
    input logic signed [CurW-1:0] v,
    input logic [ScaleW-1:0]      s
  );
    logic signed [CurW+ScaleW:0] p;
    p = v * $signed({1'b0, s});
    return p[OutW+7:8];
  endfunction

endpackage

`default_nettype wire

/* rtl/pcl_in_if.sv */
// pcl_in_if: input item channel with valid/ready handshake
`default_nettype none

interface pcl_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [pcl_pkg::PosW-1:0]            position;
  logic                                entry_direction;
  logic [pcl_pkg::IdxW-1:0]            entry_index;
  logic signed [pcl_pkg::CurW-1:0]     entry_cur_a;
  logic signed [pcl_pkg::CurW-1:0]     entry_cur_b;

  modport source (
    output valid, mode, position, entry_direction, entry_index, entry_cur_a, entry_cur_b,
    input  ready
  );

  modport sink (
    input  valid, mode, position, entry_direction, entry_index, entry_cur_a, entry_cur_b,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/pcl_out_if.sv */
// pcl_out_if: result channel with valid/ready handshake
`default_nettype none

interface pcl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      write_valid;
  logic [pcl_pkg::WordW-1:0] vector_word;
  logic [pcl_pkg::IdxW-1:0]  table_index;
  logic                      direction;
  logic [1:0]                status;

  modport source (
    output valid, write_valid, vector_word, table_index, direction, status,
    input  ready
  );

  modport sink (
    input  valid, write_valid, vector_word, table_index, direction, status,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/phase_current_lut_commutator.sv */
// phase_current_lut_commutator: table driven stepper phase current commutator, top level
//
// Takes one item per cycle while the output side is not stalled and returns one result per
// item, in order. Each item passes the input register, the table read and the result register
// in turn and transfers once the output side accepts it. The path is an input register, a read
// of the 2048 x 32 single-port current table (forward entries at slots 0..1023, reverse at
// 1024..2047) and the scaling multipliers feeding the result register; each stage holds
// only while the stage after it is full and stalled, so bubbles close up. The tables hold
// no defined contents after reset and must be loaded before a start takes effect.
`default_nettype none

module phase_current_lut_commutator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcl_pkg::CfgDataW-1:0]   cfg_data_i,
  pcl_in_if.sink                         in_if,
  pcl_out_if.source                      out_if
);

  // configuration
  logic [pcl_pkg::ScaleW-1:0] scale_q;
  logic [pcl_pkg::Log2W-1:0]  tlog_q;
  logic [pcl_pkg::Log2W-1:0]  mlog_q;
  logic                       inv_q;
  logic [pcl_pkg::IdxW-1:0]   off_q;
  logic [pcl_pkg::ScaleW-1:0] scale_wr;

  assign scale_wr = (cfg_data_i[pcl_pkg::ScaleW-1:0] > pcl_pkg::ScaleW'(pcl_pkg::ScaleUnity))
                  ? pcl_pkg::ScaleW'(pcl_pkg::ScaleUnity) : cfg_data_i[pcl_pkg::ScaleW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= pcl_pkg::ScaleW'(pcl_pkg::ScaleUnity);
      tlog_q  <= pcl_pkg::Log2W'(pcl_pkg::TableLog2);
      mlog_q  <= pcl_pkg::Log2W'(pcl_pkg::MaxMicroLog2);
      inv_q   <= 1'b0;
      off_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcl_pkg::REG_SCALE:      scale_q <= scale_wr;
        pcl_pkg::REG_TABLE_LOG2: tlog_q  <= cfg_data_i[pcl_pkg::Log2W-1:0];
        pcl_pkg::REG_MICRO_LOG2: mlog_q  <= cfg_data_i[pcl_pkg::Log2W-1:0];
        pcl_pkg::REG_INVERT:     inv_q   <= cfg_data_i[0];
        pcl_pkg::REG_OFFSET:     off_q   <= cfg_data_i[pcl_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v0_q, v1_q, v2_q;
  logic ready0, ready1, ready2;
  logic take_in, move01, move12;

  assign ready2      = !v2_q || out_if.ready;
  assign ready1      = !v1_q || ready2;
  assign ready0      = !v0_q || ready1;
  assign in_if.ready = ready0;
  assign take_in     = in_if.valid && ready0;
  assign move01      = v0_q && ready1;
  assign move12      = v1_q && ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= take_in || (v0_q && !ready1);
      v1_q <= move01 || (v1_q && !ready2);
      v2_q <= move12 || (v2_q && !out_if.ready);
    end
  end

  // input register
  logic [1:0]                      mode_q;
  logic [pcl_pkg::PosW-1:0]        pos_q;
  logic                            edir_q;
  logic [pcl_pkg::IdxW-1:0]        eidx_q;
  logic signed [pcl_pkg::CurW-1:0] ea_q;
  logic signed [pcl_pkg::CurW-1:0] eb_q;

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      mode_q <= in_if.mode;
      pos_q  <= in_if.position;
      edir_q <= in_if.entry_direction;
      eidx_q <= in_if.entry_index;
      ea_q   <= in_if.entry_cur_a;
      eb_q   <= in_if.entry_cur_b;
    end
  end

  // commutation state
  logic [pcl_pkg::PosW-1:0] prev_q, prev_d;
  logic                     mdir_q, mdir_d;
  logic [pcl_pkg::IdxW-1:0] lwi_q, lwi_d;
  logic                     lwd_q, lwd_d;
  logic                     run_q, run_d;
  logic                     fl_q, fl_d;
  logic                     rl_q, rl_d;

  logic [pcl_pkg::Log2W-1:0] tl;
  logic [pcl_pkg::IdxW:0]    size;
  logic                      in_range;
  logic                      is_last;
  logic [pcl_pkg::PosW-1:0]  delta;
  logic                      dir_tick;
  logic [pcl_pkg::IdxW-1:0]  idx_calc;
  logic                      we_c;
  pcl_pkg::pcl_meta_t        meta_d;
  pcl_pkg::pcl_ram_req_t     ram_req;

  assign tl       = pcl_pkg::tab_log2(tlog_q);
  assign size     = (pcl_pkg::IdxW+1)'(1) << tl;
  assign in_range = {1'b0, eidx_q} < size;
  assign is_last  = {1'b0, eidx_q} == (size - (pcl_pkg::IdxW+1)'(1));
  assign delta    = pos_q - prev_q;
  assign dir_tick = (delta != '0) ? delta[pcl_pkg::PosW-1] : mdir_q;
  assign idx_calc = pcl_pkg::phase_index(pos_q[pcl_pkg::IdxW-1:0], off_q, inv_q, mlog_q, tl);

  always_comb begin
    prev_d        = prev_q;
    mdir_d        = mdir_q;
    lwi_d         = lwi_q;
    lwd_d         = lwd_q;
    run_d         = run_q;
    fl_d          = fl_q;
    rl_d          = rl_q;
    we_c          = 1'b0;
    meta_d.wr     = 1'b0;
    meta_d.rd     = 1'b0;
    meta_d.status = pcl_pkg::ST_OK;
    unique case (pcl_pkg::mode_e'(mode_q))
      pcl_pkg::MODE_LOAD: begin
        if (run_q) begin
          meta_d.status = pcl_pkg::ST_LOAD_RUNNING;
        end else if (!in_range) begin
          meta_d.status = pcl_pkg::ST_RANGE;
        end else begin
          we_c = 1'b1;
          if (is_last) begin
            if (edir_q) begin
              rl_d = 1'b1;
            end else begin
              fl_d = 1'b1;
            end
          end
        end
      end
      pcl_pkg::MODE_START: begin
        run_d = 1'b0;
        if (!fl_q || !rl_q) begin
          meta_d.status = pcl_pkg::ST_NOT_LOADED;
        end else begin
          prev_d    = pos_q;
          lwi_d     = idx_calc;
          lwd_d     = mdir_q;
          run_d     = 1'b1;
          meta_d.wr = 1'b1;
          meta_d.rd = 1'b1;
        end
      end
      pcl_pkg::MODE_TICK: begin
        if (run_q) begin
          prev_d = pos_q;
          mdir_d = dir_tick;
          if (idx_calc != lwi_q || dir_tick != lwd_q) begin
            lwi_d     = idx_calc;
            lwd_d     = dir_tick;
            meta_d.wr = 1'b1;
            meta_d.rd = 1'b1;
          end
        end
      end
      pcl_pkg::MODE_STOP: begin
        run_d     = 1'b0;
        meta_d.wr = 1'b1;
      end
      default: ;
    endcase
    meta_d.idx = lwi_d;
    meta_d.dir = mdir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      mdir_q <= 1'b0;
      lwi_q  <= '0;
      lwd_q  <= 1'b0;
      run_q  <= 1'b0;
      fl_q   <= 1'b0;
      rl_q   <= 1'b0;
    end else if (move01) begin
      prev_q <= prev_d;
      mdir_q <= mdir_d;
      lwi_q  <= lwi_d;
      lwd_q  <= lwd_d;
      run_q  <= run_d;
      fl_q   <= fl_d;
      rl_q   <= rl_d;
    end
  end

  // table access
  logic [pcl_pkg::EntryW-1:0] rdata;

  assign ram_req.we    = move01 && we_c;
  assign ram_req.re    = move01 && meta_d.rd;
  assign ram_req.addr  = we_c ? {edir_q, eidx_q} : {mdir_d, idx_calc};
  assign ram_req.wdata = {ea_q, eb_q};

  pcl_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  pcl_pkg::pcl_meta_t meta1_q;

  always_ff @(posedge clk_i) begin
    if (move01) begin
      meta1_q <= meta_d;
    end
  end

  // scaling and result register
  logic [pcl_pkg::OutW-1:0]  cur_a9, cur_b9;
  logic                      wr2_q;
  logic [pcl_pkg::WordW-1:0] word2_q;
  logic [pcl_pkg::IdxW-1:0]  idx2_q;
  logic                      dir2_q;
  pcl_pkg::status_e          status2_q;

  assign cur_a9 = pcl_pkg::scale_9(rdata[pcl_pkg::EntryW-1:pcl_pkg::CurW], scale_q);
  assign cur_b9 = pcl_pkg::scale_9(rdata[pcl_pkg::CurW-1:0], scale_q);

  always_ff @(posedge clk_i) begin
    if (move12) begin
      wr2_q     <= meta1_q.wr;
      word2_q   <= meta1_q.rd ? {cur_b9, 7'b0, cur_a9} : '0;
      idx2_q    <= meta1_q.idx;
      dir2_q    <= meta1_q.dir;
      status2_q <= meta1_q.status;
    end
  end

  assign out_if.valid       = v2_q;
  assign out_if.write_valid = wr2_q;
  assign out_if.vector_word = word2_q;
  assign out_if.table_index = idx2_q;
  assign out_if.direction   = dir2_q;
  assign out_if.status      = status2_q;

endmodule

`default_nettype wire

/* rtl/pcl_ram.sv */
// pcl_ram: single-port current table memory with registered read
`default_nettype none

module pcl_ram (
  input  logic                               clk_i,
  input  pcl_pkg::pcl_ram_req_t              req_i,
  output logic [pcl_pkg::EntryW-1:0]         rdata_o
);

  logic [pcl_pkg::EntryW-1:0] mem_q [pcl_pkg::TableSlots];
  logic [pcl_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/pcl_checker.sv */
// pcl_checker: port level assertions for the phase current commutator, with its bind
`default_nettype none

module pcl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      write_valid_i,
  input logic [pcl_pkg::WordW-1:0] vector_word_i,
  input logic [1:0]                status_i
);

  // no vector issued means a zero word
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !write_valid_i |-> vector_word_i == '0)
    else $error("vector word nonzero without write");

  // any error status comes without a vector
  a_no_write_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != pcl_pkg::ST_OK |-> !write_valid_i)
    else $error("vector issued with error status");

  // gap between the two packed phase fields stays clear
  a_pack_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> vector_word_i[15:9] == '0)
    else $error("vector word gap bits set");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(vector_word_i))
    else $error("stalled result changed");

endmodule

bind phase_current_lut_commutator pcl_checker u_pcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .write_valid_i (out_if.write_valid),
  .vector_word_i (out_if.vector_word),
  .status_i      (out_if.status)
);

`default_nettype wire
